>>> sv/hhbp_pkg.sv
// ----------------------------------------------------------------------------
// HTTP header byte parser package
// This package holds the parser state codes, the result kind codes, the
// character constants and the step result structure.
// ----------------------------------------------------------------------------
package hhbp_pkg;

   localparam int unsigned STATE_W  = 4;
   localparam int unsigned OFFSET_W = 12;
   localparam int unsigned KIND_W   = 3;

   localparam logic [STATE_W-1:0] ST_START  = 4'd0;
   localparam logic [STATE_W-1:0] ST_KEY    = 4'd1;
   localparam logic [STATE_W-1:0] ST_COLON  = 4'd2;
   localparam logic [STATE_W-1:0] ST_SPACE  = 4'd3;
   localparam logic [STATE_W-1:0] ST_VALUE  = 4'd4;
   localparam logic [STATE_W-1:0] ST_CR     = 4'd5;
   localparam logic [STATE_W-1:0] ST_LF     = 4'd6;
   localparam logic [STATE_W-1:0] ST_END_CR = 4'd7;
   localparam logic [STATE_W-1:0] ST_DONE   = 4'd8;
   localparam logic [STATE_W-1:0] ST_ERROR  = 4'd9;

   localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_KEY   = 3'd1;
   localparam logic [KIND_W-1:0] KIND_VALUE = 3'd2;
   localparam logic [KIND_W-1:0] KIND_LINE  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_DONE  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR = 3'd5;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SP    = 8'h20;

   localparam logic [OFFSET_W-1:0] OFFSET_MAX   = 12'hFFF;
   localparam logic [OFFSET_W-1:0] MAX_OFF_RST  = 12'd255;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam logic [0:0]  REG_MAX_VALUE_OFFSET = 1'b0;

   typedef struct packed {
      logic [STATE_W-1:0]  state;
      logic [OFFSET_W-1:0] offset;
      logic [KIND_W-1:0]   kind;
      logic [7:0]          echo_byte;
   } step_type;

endpackage

>>> sv/hhbp_step.sv
// ----------------------------------------------------------------------------
// HTTP header byte parser step logic
// Combinational next state, value offset and result tag for one input byte.
// ----------------------------------------------------------------------------
module hhbp_step (
   input  logic [hhbp_pkg::STATE_W-1:0]  state,
   input  logic [hhbp_pkg::OFFSET_W-1:0] offset,
   input  logic [hhbp_pkg::OFFSET_W-1:0] max_offset,
   input  logic [7:0]                    data_byte,
   input  logic                          block_start,
   output hhbp_pkg::step_type            step
);
   import hhbp_pkg::*;

   logic [STATE_W-1:0]  cur_state;
   logic [OFFSET_W-1:0] cur_offset;
   logic [OFFSET_W-1:0] inc_offset;
   logic [STATE_W-1:0]  nxt_state;
   logic [OFFSET_W-1:0] nxt_offset;
   logic [KIND_W-1:0]   kind;
   logic                is_crlf;

   always_comb begin
      cur_state  = block_start ? ST_START : state;
      cur_offset = block_start ? '0 : offset;
      inc_offset = (cur_offset < OFFSET_MAX) ? cur_offset + OFFSET_W'(1) : cur_offset;
      is_crlf    = (data_byte == CH_CR) || (data_byte == CH_LF);
      nxt_state  = cur_state;
      nxt_offset = cur_offset;
      kind       = KIND_SKIP;
      unique case (cur_state)
         ST_START: begin
            if (!is_crlf) begin
               kind      = KIND_KEY;
               nxt_state = ST_KEY;
            end
         end
         ST_KEY: begin
            if (data_byte == CH_COLON) begin
               nxt_state = ST_COLON;
            end else if (is_crlf) begin
               kind      = KIND_ERROR;
               nxt_state = ST_ERROR;
            end else begin
               kind = KIND_KEY;
            end
         end
         ST_COLON: begin
            if (data_byte == CH_SP) begin
               nxt_state = ST_SPACE;
            end else begin
               kind      = KIND_ERROR;
               nxt_state = ST_ERROR;
            end
         end
         ST_SPACE: begin
            kind       = KIND_VALUE;
            nxt_offset = '0;
            nxt_state  = ST_VALUE;
         end
         ST_VALUE: begin
            if (data_byte == CH_CR) begin
               nxt_state = ST_CR;
            end else begin
               nxt_offset = inc_offset;
               if (inc_offset > max_offset) begin
                  kind      = KIND_ERROR;
                  nxt_state = ST_ERROR;
               end else begin
                  kind = KIND_VALUE;
               end
            end
         end
         ST_CR: begin
            if (data_byte == CH_LF) begin
               kind      = KIND_LINE;
               nxt_state = ST_LF;
            end else begin
               kind      = KIND_ERROR;
               nxt_state = ST_ERROR;
            end
         end
         ST_LF: begin
            if (data_byte == CH_CR) begin
               nxt_state = ST_END_CR;
            end else begin
               kind      = KIND_KEY;
               nxt_state = ST_KEY;
            end
         end
         ST_END_CR: begin
            if (data_byte == CH_LF) begin
               kind      = KIND_DONE;
               nxt_state = ST_DONE;
            end else begin
               kind      = KIND_ERROR;
               nxt_state = ST_ERROR;
            end
         end
         ST_DONE: begin
            kind = KIND_DONE;
         end
         default: begin
            kind      = KIND_ERROR;
            nxt_state = ST_ERROR;
         end
      endcase
      step.state     = nxt_state;
      step.offset    = nxt_offset;
      step.kind      = kind;
      step.echo_byte = ((kind == KIND_KEY) || (kind == KIND_VALUE)) ? data_byte : 8'h00;
   end

endmodule

>>> sv/http_header_byte_parser.sv
// ----------------------------------------------------------------------------
// HTTP header byte parser
// Tags each byte of an HTTP header section as skipped, key byte, value byte,
// header line done, block done or error.
//
//   Channel   Direction  Handshake                Payload
//   req       in         req_valid / req_ready    req_data_byte, req_block_start
//   rsp       out        rsp_valid / rsp_ready    rsp_kind, rsp_echo_byte
//   csr       in         APB, pready tied high    max_value_offset at address 0
//
// Each accepted byte gets a registered result, and one byte can be accepted
// every cycle while the result register can take it. The parser state
// updates together with the result register. A new byte is taken while the
// result register is empty or its result is being taken. Reset clears the
// parser to line start and sets max_value_offset to 255.
// ----------------------------------------------------------------------------
module http_header_byte_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_block_start,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hhbp_pkg::KIND_W-1:0]     rsp_kind,
   output logic [7:0]                      rsp_echo_byte,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [hhbp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);
   import hhbp_pkg::*;

   logic [STATE_W-1:0]  state_ff, state_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   logic [OFFSET_W-1:0] max_offset_ff, max_offset_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]   rsp_kind_ff, rsp_kind_in;
   logic [7:0]          rsp_echo_byte_ff, rsp_echo_byte_in;
   logic                req_take;
   logic                csr_write;
   logic                csr_hit;
   step_type            step;

   hhbp_step u_step (
      .state       (state_ff),
      .offset      (offset_ff),
      .max_offset  (max_offset_ff),
      .data_byte   (req_data_byte),
      .block_start (req_block_start),
      .step        (step)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_take   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1] == REG_MAX_VALUE_OFFSET);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit;
   assign csr_prdata = csr_hit ? {{(32-OFFSET_W){1'b0}}, max_offset_ff} : 32'h0;

   always_comb begin
      state_in         = state_ff;
      offset_in        = offset_ff;
      max_offset_in    = csr_write ? csr_pwdata[OFFSET_W-1:0] : max_offset_ff;
      rsp_valid_in     = rsp_valid_ff && !rsp_ready;
      rsp_kind_in      = rsp_kind_ff;
      rsp_echo_byte_in = rsp_echo_byte_ff;
      if (req_take) begin
         state_in         = step.state;
         offset_in        = step.offset;
         rsp_valid_in     = 1'b1;
         rsp_kind_in      = step.kind;
         rsp_echo_byte_in = step.echo_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_START;
         offset_ff     <= '0;
         max_offset_ff <= MAX_OFF_RST;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         offset_ff     <= offset_in;
         max_offset_ff <= max_offset_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_kind_ff      <= rsp_kind_in;
      rsp_echo_byte_ff <= rsp_echo_byte_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_kind      = rsp_kind_ff;
   assign rsp_echo_byte = rsp_echo_byte_ff;

endmodule

>>> tb/tb_http_header_byte_parser.sv
// ----------------------------------------------------------------------------
// HTTP header byte parser testbench
// Streams header sections through the parser and predicts the tag of every
// byte in a small scoreboard, which compares each result transaction field by
// field. Well-formed blocks with random content, corrupted blocks and noise
// are sent under several value offset limits. Both sides idle at random, and
// the receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
module tb_http_header_byte_parser;
   import hhbp_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] ADDR_MAX_VALUE_OFFSET =
      CSR_ADDR_W'(4 * int'(REG_MAX_VALUE_OFFSET));
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED =
      CSR_ADDR_W'(4 * (int'(REG_MAX_VALUE_OFFSET) + 1));
   localparam int PHASES = 8;
   localparam int PHASE_ITEMS = 90;
   localparam logic [31:0] CFG_VALUES [PHASES] = '{
      32'h0000_0000, 32'h0000_0FFF, 32'hFFFF_F003, 32'h0000_00FF,
      32'h0000_0001, 32'h0000_0000, 32'h0000_0011, 32'h0000_0FFF
   };
   localparam logic [8:0] DIRECTED [25] = '{
      {1'b1, CH_CR},    {1'b0, CH_LF},    {1'b0, 8'hFF},    {1'b0, 8'h00},
      {1'b0, CH_COLON}, {1'b0, CH_SP},    {1'b0, CH_CR},    {1'b0, 8'hFF},
      {1'b0, CH_CR},    {1'b0, CH_LF},    {1'b0, CH_LF},    {1'b0, CH_COLON},
      {1'b0, 8'h78},    {1'b0, 8'h61},    {1'b1, 8'h41},    {1'b0, CH_CR},
      {1'b1, CH_COLON}, {1'b0, CH_COLON}, {1'b0, CH_SP},    {1'b0, 8'h76},
      {1'b0, CH_CR},    {1'b0, CH_LF},    {1'b0, CH_CR},    {1'b0, CH_LF},
      {1'b0, 8'h55}
   };

   class header_tag_scoreboard;
      logic [OFFSET_W-1:0] max_offset = MAX_OFF_RST;
      logic [STATE_W-1:0]  parse_state = ST_START;
      logic [OFFSET_W-1:0] value_offset = '0;
      logic [KIND_W-1:0]   kind_q[$];
      logic [7:0]          echo_q[$];
      int                  mismatches = 0;

      function void flag(input string msg);
         mismatches++;
         if (mismatches <= 10) $display("mismatch: %s", msg);
      endfunction

      function void write_register(input int index, input logic [31:0] value);
         if (index == int'(REG_MAX_VALUE_OFFSET)) max_offset = value[OFFSET_W-1:0];
      endfunction

      function void check_register(input logic [31:0] value);
         if (value !== 32'(max_offset))
            flag($sformatf("max_value_offset read expected %0d actual %0d",
                           max_offset, value));
      endfunction

      function void note_byte(input logic [7:0] data, input logic start);
         logic [KIND_W-1:0] kind;
         kind = KIND_SKIP;
         if (start) begin
            parse_state  = ST_START;
            value_offset = '0;
         end
         case (parse_state)
            ST_START: begin
               if (data != CH_CR && data != CH_LF) begin
                  kind        = KIND_KEY;
                  parse_state = ST_KEY;
               end
            end
            ST_KEY: begin
               if (data == CH_COLON) begin
                  parse_state = ST_COLON;
               end else if (data == CH_CR || data == CH_LF) begin
                  kind        = KIND_ERROR;
                  parse_state = ST_ERROR;
               end else begin
                  kind = KIND_KEY;
               end
            end
            ST_COLON: begin
               if (data == CH_SP) begin
                  parse_state = ST_SPACE;
               end else begin
                  kind        = KIND_ERROR;
                  parse_state = ST_ERROR;
               end
            end
            ST_SPACE: begin
               kind         = KIND_VALUE;
               value_offset = '0;
               parse_state  = ST_VALUE;
            end
            ST_VALUE: begin
               if (data == CH_CR) begin
                  parse_state = ST_CR;
               end else begin
                  if (value_offset != OFFSET_MAX) value_offset++;
                  if (value_offset > max_offset) begin
                     kind        = KIND_ERROR;
                     parse_state = ST_ERROR;
                  end else begin
                     kind = KIND_VALUE;
                  end
               end
            end
            ST_CR: begin
               if (data == CH_LF) begin
                  kind        = KIND_LINE;
                  parse_state = ST_LF;
               end else begin
                  kind        = KIND_ERROR;
                  parse_state = ST_ERROR;
               end
            end
            ST_LF: begin
               if (data == CH_CR) begin
                  parse_state = ST_END_CR;
               end else begin
                  kind        = KIND_KEY;
                  parse_state = ST_KEY;
               end
            end
            ST_END_CR: begin
               if (data == CH_LF) begin
                  kind        = KIND_DONE;
                  parse_state = ST_DONE;
               end else begin
                  kind        = KIND_ERROR;
                  parse_state = ST_ERROR;
               end
            end
            ST_DONE: begin
               kind = KIND_DONE;
            end
            default: begin
               kind        = KIND_ERROR;
               parse_state = ST_ERROR;
            end
         endcase
         kind_q.push_back(kind);
         echo_q.push_back((kind == KIND_KEY || kind == KIND_VALUE) ? data : 8'h00);
      endfunction

      function void check_tag(input logic [KIND_W-1:0] kind, input logic [7:0] echo);
         logic [KIND_W-1:0] exp_kind;
         logic [7:0]        exp_echo;
         if (kind_q.size() == 0) begin
            flag($sformatf("unexpected result kind %0d echo %02h", kind, echo));
            return;
         end
         exp_kind = kind_q.pop_front();
         exp_echo = echo_q.pop_front();
         if (kind !== exp_kind)
            flag($sformatf("kind expected %0d actual %0d", exp_kind, kind));
         if (echo !== exp_echo)
            flag($sformatf("echo_byte expected %02h actual %02h", exp_echo, echo));
      endfunction

      function int pending();
         return kind_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [7:0]            req_data_byte = '0;
   logic                  req_block_start = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [KIND_W-1:0]     rsp_kind;
   logic [7:0]            rsp_echo_byte;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0]           csr_pwdata = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   header_tag_scoreboard sb = new;
   int send_idle_pct = 10;
   int recv_idle_pct = 70;
   int corrupt_pct = 0;
   int items_sent = 0;
   int hold_left = 0;
   bit hold_req = 1'b0;
   bit hold_issued = 1'b0;
   bit pause_done = 1'b0;
   bit start_next = 1'b0;

   http_header_byte_parser uut (.*);

   always #2 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) sb.check_tag(rsp_kind, rsp_echo_byte);
         if (hold_req) begin
            hold_left = 80;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         end
      end
   end

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.write_register(int'(addr >> 2), value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_read_check();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= ADDR_MAX_VALUE_OFFSET;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      sb.check_register(csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_idle();
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_byte(input logic [7:0] data, input logic start);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= data;
      req_block_start <= start;
      do @(posedge clock); while (req_ready !== 1'b1);
      sb.note_byte(data, start);
      items_sent++;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return CH_CR;
         1: return CH_LF;
         2: return CH_COLON;
         3: return CH_SP;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] rand_byte_except(input bit no_cr, input bit no_lf,
                                                   input bit no_colon);
      logic [7:0] data;
      do data = 8'($urandom);
      while ((no_cr && data == CH_CR) || (no_lf && data == CH_LF) ||
             (no_colon && data == CH_COLON));
      return data;
   endfunction

   function automatic int value_len();
      int lim;
      lim = int'(sb.max_offset);
      if (lim < 8) return $urandom_range(1, lim + 2);
      if ($urandom_range(0, 29) == 0 && lim <= 300) return lim + $urandom_range(1, 2);
      return $urandom_range(1, 8);
   endfunction

   task automatic send_text(input logic [7:0] data);
      logic [7:0] data_out;
      data_out = data;
      if ($urandom_range(0, 99) < corrupt_pct) data_out = pick_byte();
      send_byte(data_out, start_next);
      start_next = 1'b0;
   endtask

   task automatic send_block(input int forced_len);
      int lines;
      int vlen;
      start_next = 1'b1;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 2)) send_text($urandom_range(0, 1) ? CH_CR : CH_LF);
      lines = (forced_len > 0) ? 1 : $urandom_range(0, 4);
      for (int i = 0; i < lines; i++) begin
         if (i > 0 && $urandom_range(0, 7) == 0) send_text(CH_LF);
         else send_text(rand_byte_except(1'b1, 1'b1, 1'b0));
         repeat ($urandom_range(0, 5)) send_text(rand_byte_except(1'b1, 1'b1, 1'b1));
         send_text(CH_COLON);
         send_text(CH_SP);
         vlen = (forced_len > 0) ? forced_len : value_len();
         send_text(($urandom_range(0, 7) == 0) ? CH_CR : rand_byte_except(1'b1, 1'b0, 1'b0));
         repeat (vlen - 1) send_text(rand_byte_except(1'b1, 1'b0, 1'b0));
         send_text(CH_CR);
         send_text(CH_LF);
      end
      send_text(CH_CR);
      send_text(CH_LF);
      repeat ($urandom_range(0, 2)) send_text(pick_byte());
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(pick_byte(), $urandom_range(0, 7) == 0);
   endtask

   initial begin
      logic [31:0] cfg;
      int          pick;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check();
      foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
      for (int p = 0; p < PHASES; p++) begin
         req_valid <= 1'b0;
         wait_idle();
         send_idle_pct = (p < 3) ? 10 : (p < 6) ? 70 : 0;
         recv_idle_pct = (p < 3) ? 70 : (p < 6) ? 10 : 0;
         cfg = (p == 5) ? $urandom : CFG_VALUES[p];
         csr_write(ADDR_MAX_VALUE_OFFSET, cfg);
         if (p == 2) csr_write(ADDR_UNMAPPED, $urandom);
         csr_read_check();
         items_sent = 0;
         while (items_sent < PHASE_ITEMS) begin
            if (p == 6 && !hold_issued && items_sent > 20) begin
               hold_req    = 1'b1;
               hold_issued = 1'b1;
            end
            if (p == 3 && !pause_done && items_sent > 40) begin
               req_valid <= 1'b0;
               wait_idle();
               pause_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            corrupt_pct = (pick < 3) ? 4 : 0;
            if (pick == 0) send_noise($urandom_range(1, 12));
            else send_block(0);
         end
      end
      req_valid <= 1'b0;
      wait_idle();
      if (sb.mismatches == 0 && sb.pending() == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      #2000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule

>>> http_header_byte_parser.f
sv/hhbp_pkg.sv
sv/hhbp_step.sv
sv/http_header_byte_parser.sv
tb/tb_http_header_byte_parser.sv
